/* hdl/rwsa_pkg.sv */
// rwsa_pkg: field widths, register indexes, reset values and operation codes
// for the retry weighted sleep averager. No dependencies.
`timescale 1ns / 1ps

package rwsa_pkg;

	// payload widths
	localparam int INTERVAL_W = 16;
	localparam int RETRY_W    = 8;
	localparam int CFG_IDX_W  = 2;

	typedef logic [INTERVAL_W-1:0] interval_t;
	typedef logic [RETRY_W-1:0]    retry_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	// operation codes
	localparam logic OP_FILL   = 1'b0;
	localparam logic OP_RECORD = 1'b1;

	// configuration register indexes
	localparam cfg_idx_t CFG_BASE_INTERVAL = 2'd0;
	localparam cfg_idx_t CFG_TOP_INTERVAL  = 2'd1;
	localparam cfg_idx_t CFG_MAX_RETRIES   = 2'd2;

	// configuration reset values
	localparam interval_t BASE_INTERVAL_RST = 16'd40;
	localparam interval_t TOP_INTERVAL_RST  = 16'd300;
	localparam retry_t    MAX_RETRIES_RST   = 8'd6;

	// width of interval difference times retry count
	localparam int MAP_W = INTERVAL_W + RETRY_W;

endpackage

/* hdl/retry_weighted_sleep_averager.sv */
// retry_weighted_sleep_averager: moving average of recent sleep intervals with
// a serial restoring divider for the retry mapping and a reciprocal multiply for the average.
// Depends on rwsa_pkg.
`timescale 1ns / 1ps

// Usage
// Item channel (item_valid / item_stall, fields op, fill_value, attempts):
//   op = fill writes fill_value to every window entry; op = record maps
//   attempts linearly between base_interval and interval_at_max_retries
//   (divided by max_retries, result saturated to 16 bits) and writes it at the
//   rotating write position. Each transaction yields one result transaction.
// Result channel (result_valid / result_stall, field next_sleep): floor of the
//   window sum divided by WINDOW_SIZE after the item's update (constant multiply).
// Timing: one restoring divider produces one quotient bit a cycle.
//   fill:   acceptance goes straight to the output step, which loads the result.
//   record: read, 24 divide steps, update, then the output step loads the result.
//   A new item is taken only once the previous one has left the output step;
//   item_stall is high while an item is in work.
// The result register parts the channels: a new transaction is taken while a
//   result waits; a finished item holds in the output step while result_stall
//   keeps the register full, and item_stall stays high meanwhile.
// Reset: configuration returns to 40 / 300 / 6, window reads as all zero,
//   write position and sum cleared, no result pending. The user must make
//   configuration writes (cfg_we, cfg_index, cfg_data) only while idle; not enforced.

module retry_weighted_sleep_averager #(
	parameter int WINDOW_SIZE = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write port
	input  logic                     cfg_we,
	input  rwsa_pkg::cfg_idx_t       cfg_index,
	input  rwsa_pkg::interval_t      cfg_data,
	// item channel
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     op,
	input  rwsa_pkg::interval_t      fill_value,
	input  rwsa_pkg::retry_t         attempts,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output rwsa_pkg::interval_t      next_sleep
);

	// derived sizes
	localparam int WIN_AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int SUM_W  = rwsa_pkg::INTERVAL_W + $clog2(WINDOW_SIZE);
	localparam int DIV_W  = rwsa_pkg::MAP_W;
	localparam int DVS_W  = rwsa_pkg::RETRY_W;
	localparam int CNT_W  = $clog2(DIV_W + 1);
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_SIZE * 65535);

	// average: floor(sum / WINDOW_SIZE) = (sum * AVG_RCP) >> AVG_SH, exact for sum < 2^SUM_W
	localparam int AVG_SH = SUM_W + $clog2(WINDOW_SIZE);
	localparam int RCP_W  = SUM_W + 2;
	localparam int AVP_W  = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] AVG_RCP =
		RCP_W'((64'd1 << AVG_SH) / 64'(WINDOW_SIZE) + 64'd1);

	// sequencer
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]                state_q;

	// configuration
	rwsa_pkg::interval_t       base_q;
	rwsa_pkg::interval_t       top_q;
	rwsa_pkg::retry_t          max_retries_q;

	// item
	rwsa_pkg::retry_t          attempts_q;

	// window state: an entry that is not valid reads as fill_q
	logic [15:0]               win_mem [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0]    ent_valid_q;
	rwsa_pkg::interval_t       fill_q;
	logic [WIN_AW-1:0]         wpos_q;
	logic [SUM_W-1:0]          sum_q;
	rwsa_pkg::interval_t       mem_rd_q;
	logic                      old_valid_q;

	// divider
	logic [DIV_W-1:0]          quo_q;
	logic [DVS_W-1:0]          rem_q;
	logic [CNT_W-1:0]          cnt_q;

	// result register
	logic                      result_valid_q;
	rwsa_pkg::interval_t       next_sleep_q;

	// combinational
	logic                      item_acc;
	logic                      out_free;
	logic                      falling;
	rwsa_pkg::interval_t       abs_diff;
	logic [rwsa_pkg::MAP_W-1:0] prod;
	logic [DVS_W-1:0]          divisor;
	logic [DVS_W:0]            shifted;
	logic                      quo_bit;
	logic [DVS_W:0]            rem_sub;
	logic [DVS_W-1:0]          rem_nx;
	logic [rwsa_pkg::MAP_W-1:0] step;
	logic [rwsa_pkg::MAP_W:0]  rise_sum;
	rwsa_pkg::interval_t       mapped;
	rwsa_pkg::interval_t       old_entry;
	logic [SUM_W-1:0]          fill_sum;
	logic [SUM_W-1:0]          upd_sum;
	logic [AVP_W-1:0]          avg_prod;

	assign item_stall   = (state_q != S_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign next_sleep   = next_sleep_q;

	// retry slope: |top - base| * attempts
	assign falling  = (top_q < base_q);
	assign abs_diff = falling ? (base_q - top_q) : (top_q - base_q);
	assign prod     = rwsa_pkg::MAP_W'(abs_diff) * rwsa_pkg::MAP_W'(attempts_q);

	// restoring divider step, one quotient bit a cycle; zero divisor acts as one
	assign divisor = (max_retries_q == '0) ? DVS_W'(1) : max_retries_q;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign quo_bit = (shifted >= {1'b0, divisor});
	assign rem_sub = shifted - {1'b0, divisor};
	assign rem_nx  = quo_bit ? rem_sub[DVS_W-1:0] : shifted[DVS_W-1:0];

	// mapped interval with saturation
	assign step     = quo_q[rwsa_pkg::MAP_W-1:0];
	assign rise_sum = {1'b0, step} + (rwsa_pkg::MAP_W + 1)'(base_q);
	always_comb begin
		if (falling) begin
			if (step >= rwsa_pkg::MAP_W'(base_q)) begin
				mapped = '0;
			end else begin
				mapped = base_q - step[rwsa_pkg::INTERVAL_W-1:0];
			end
		end else if (rise_sum > (rwsa_pkg::MAP_W + 1)'(16'hFFFF)) begin
			mapped = 16'hFFFF;
		end else begin
			mapped = rise_sum[rwsa_pkg::INTERVAL_W-1:0];
		end
	end

	assign old_entry = old_valid_q ? mem_rd_q : fill_q;
	assign fill_sum  = SUM_W'(fill_value) * SUM_W'(WINDOW_SIZE);
	assign upd_sum   = sum_q - SUM_W'(old_entry) + SUM_W'(mapped);
	assign avg_prod  = AVP_W'(sum_q) * AVP_W'(AVG_RCP);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q        <= rwsa_pkg::BASE_INTERVAL_RST;
			top_q         <= rwsa_pkg::TOP_INTERVAL_RST;
			max_retries_q <= rwsa_pkg::MAX_RETRIES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rwsa_pkg::CFG_BASE_INTERVAL: base_q <= cfg_data;
				rwsa_pkg::CFG_TOP_INTERVAL:  top_q  <= cfg_data;
				rwsa_pkg::CFG_MAX_RETRIES:   max_retries_q <= cfg_data[rwsa_pkg::RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	// window memory, registered read
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			win_mem[wpos_q] <= mapped;
		end
		if (state_q == S_MUL) begin
			mem_rd_q <= win_mem[wpos_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_acc) begin
			attempts_q <= attempts;
		end
		if (state_q == S_MUL) begin
			old_valid_q <= ent_valid_q[wpos_q];
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			quo_q <= prod;
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			quo_q <= {quo_q[DIV_W-2:0], quo_bit};
			rem_q <= rem_nx;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			ent_valid_q    <= '0;
			fill_q         <= '0;
			wpos_q         <= '0;
			sum_q          <= '0;
			result_valid_q <= 1'b0;
			next_sleep_q   <= '0;
		end else begin
			// result register: loaded from the output step, cleared when taken
			if (state_q == S_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (op == rwsa_pkg::OP_FILL) begin
							// fill: every entry reads as the new value
							ent_valid_q <= '0;
							fill_q      <= fill_value;
							sum_q       <= fill_sum;
							state_q     <= S_OUT;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q   <= CNT_W'(DIV_W);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					ent_valid_q[wpos_q] <= 1'b1;
					sum_q  <= upd_sum;
					wpos_q <= (wpos_q == WIN_AW'(WINDOW_SIZE - 1)) ? '0 : wpos_q + WIN_AW'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						next_sleep_q <= avg_prod[AVG_SH +: rwsa_pkg::INTERVAL_W];
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= WIN_AW'(WINDOW_SIZE - 1))
		else $error("write position beyond window");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_MAX)
		else $error("window sum beyond bound");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q != '0)
		else $error("divider running with zero count");

	a_fill_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && op == rwsa_pkg::OP_FILL |=> ent_valid_q == '0)
		else $error("fill left window entries valid");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output step");
`endif

endmodule

/* tb/tb.sv */
// tb: self-checking bench for retry_weighted_sleep_averager, with a directed table
// then randomised phases, checked against an in-bench window model or typed-in results.
// Depends on rwsa_pkg and the retry_weighted_sleep_averager RTL.
`timescale 1ns / 1ps

module tb;

	localparam int WIN         = 8;
	localparam int LIMIT       = 800000;   // cycles before the watchdog gives up
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 250;
	localparam int HOLD_AFTER  = 400;      // results seen before the long hold-off
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 64;
	localparam rwsa_pkg::cfg_idx_t CFG_SPARE = 2'd3; // unmapped index, must be ignored

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	// one row of the directed table: either a register setting or a transaction
	typedef struct {
		bit                  is_cfg;
		logic                op;
		rwsa_pkg::interval_t fill;
		rwsa_pkg::retry_t    tries;
		rwsa_pkg::interval_t base;
		rwsa_pkg::interval_t top;
		rwsa_pkg::retry_t    maxr;
		int                  want;   // typed-in result, or -1 to take the window model's
	} plan_row_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                cfg_we       = 1'b0;
	rwsa_pkg::cfg_idx_t  cfg_index    = '0;
	rwsa_pkg::interval_t cfg_data     = '0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	logic                op           = rwsa_pkg::OP_FILL;
	rwsa_pkg::interval_t fill_value   = '0;
	rwsa_pkg::retry_t    attempts     = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	rwsa_pkg::interval_t next_sleep;

	// window model state, mirrors the block's registers
	rwsa_pkg::interval_t cfg_base = rwsa_pkg::BASE_INTERVAL_RST;
	rwsa_pkg::interval_t cfg_top  = rwsa_pkg::TOP_INTERVAL_RST;
	rwsa_pkg::retry_t    cfg_maxr = rwsa_pkg::MAX_RETRIES_RST;
	rwsa_pkg::interval_t win_q[WIN];
	int                  wr_pos   = 0;
	logic [31:0]         win_sum  = '0;

	rwsa_pkg::interval_t pending_sleep[$];   // averages still owed by the block
	rwsa_pkg::interval_t due_sleep;
	plan_row_t plan[$];

	int n_fill    = 0;
	int n_record  = 0;
	int n_cfg     = 0;
	int n_results = 0;
	int n_checked = 0;
	int errors    = 0;
	int cycle_cnt = 0;
	bit held      = 1'b0;

	retry_weighted_sleep_averager #(.WINDOW_SIZE(WIN)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.op          (op),
		.fill_value  (fill_value),
		.attempts    (attempts),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.next_sleep  (next_sleep)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Linear retry map. Full-width arithmetic; the step is truncated before it is
	// applied, so a falling slope rounds towards base. Saturates at both ends.
	function automatic rwsa_pkg::interval_t mapped_interval(rwsa_pkg::retry_t tries);
		logic [31:0] div, base, top, step;
		div  = (cfg_maxr == '0) ? 32'd1 : {24'd0, cfg_maxr};   // zero divisor acts as one
		base = {16'd0, cfg_base};
		top  = {16'd0, cfg_top};
		if (top >= base) begin
			step = ((top - base) * {24'd0, tries}) / div;
			if (base + step > 32'hFFFF)
				return 16'hFFFF;
			return rwsa_pkg::interval_t'(base + step);
		end
		step = ((base - top) * {24'd0, tries}) / div;
		if (step >= base)
			return '0;
		return rwsa_pkg::interval_t'(base - step);
	endfunction

	// Applies one transaction to the window model and returns the new average.
	// A fill leaves the write position where it was.
	function automatic rwsa_pkg::interval_t predict_next_sleep(logic o,
		rwsa_pkg::interval_t f, rwsa_pkg::retry_t t);
		rwsa_pkg::interval_t v;
		if (o == rwsa_pkg::OP_FILL) begin
			foreach (win_q[i])
				win_q[i] = f;
			win_sum = 32'(f) * WIN;
		end else begin
			v = mapped_interval(t);
			win_sum = win_sum - 32'(win_q[wr_pos]) + 32'(v);
			win_q[wr_pos] = v;
			wr_pos = (wr_pos + 1) % WIN;
		end
		return rwsa_pkg::interval_t'(win_sum / WIN);
	endfunction

	function automatic void add_item(logic o, rwsa_pkg::interval_t f, rwsa_pkg::retry_t t,
		int want);
		plan_row_t r;
		r = '{is_cfg: 1'b0, op: o, fill: f, tries: t, base: '0, top: '0, maxr: '0,
			want: want};
		plan.push_back(r);
	endfunction

	function automatic void add_cfg(rwsa_pkg::interval_t b, rwsa_pkg::interval_t t,
		rwsa_pkg::retry_t m);
		plan_row_t r;
		r = '{is_cfg: 1'b1, op: rwsa_pkg::OP_FILL, fill: '0, tries: '0, base: b, top: t,
			maxr: m, want: -1};
		plan.push_back(r);
	endfunction

	// Called on a falling edge, returns on a falling edge with valid still high,
	// so back-to-back transactions need no extra assignment to item_valid.
	task automatic offer(logic o, rwsa_pkg::interval_t f, rwsa_pkg::retry_t t, int want);
		rwsa_pkg::interval_t p;
		item_valid <= 1'b1;
		op         <= o;
		fill_value <= f;
		attempts   <= t;
		do @(posedge clk); while (item_stall);
		p = predict_next_sleep(o, f, t);
		pending_sleep.push_back((want >= 0) ? rwsa_pkg::interval_t'(want) : p);
		if (o == rwsa_pkg::OP_FILL)
			n_fill++;
		else
			n_record++;
		@(negedge clk);
	endtask

	// Registers only change with the block idle: every owed result must be back.
	// The unmapped index and the upper bits of the retry register get junk.
	task automatic program_regs(rwsa_pkg::interval_t b, rwsa_pkg::interval_t t,
		rwsa_pkg::retry_t m);
		item_valid <= 1'b0;
		while (pending_sleep.size() != 0)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= rwsa_pkg::CFG_BASE_INTERVAL;
		cfg_data  <= b;
		@(negedge clk);
		cfg_index <= rwsa_pkg::CFG_TOP_INTERVAL;
		cfg_data  <= t;
		@(negedge clk);
		cfg_index <= rwsa_pkg::CFG_MAX_RETRIES;
		cfg_data  <= {8'($urandom), m};
		@(negedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data  <= 16'($urandom);
		@(negedge clk);
		cfg_we   <= 1'b0;
		cfg_base = b;
		cfg_top  = t;
		cfg_maxr = m;
		n_cfg++;
	endtask

	// result side: compare every accepted transaction with the oldest owed average
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (pending_sleep.size() == 0) begin
				$error("unexpected transaction: next_sleep %0d", next_sleep);
				errors++;
			end else begin
				due_sleep = pending_sleep.pop_front();
				n_checked++;
				if (next_sleep !== due_sleep) begin
					$error("next_sleep: expected %0d, got %0d", due_sleep, next_sleep);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: stall modes chosen at random for random stretches, plus one long
	// hold-off mid-run so the result register fills and item_stall backs up.
	initial begin
		int          hold_left;
		int          mode_left;
		stall_mode_t mode;
		hold_left = 0;
		mode_left = 0;
		mode      = STALL_NONE;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (!held && n_results >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					STALL_NONE:  result_stall <= 1'b0;
					STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
					default:     result_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// sender: directed table first, then randomised phases
	initial begin
		plan_row_t           row;
		int                  burst;
		int                  gap;
		logic                o;
		rwsa_pkg::interval_t f;
		rwsa_pkg::interval_t b;
		rwsa_pkg::interval_t tp;
		rwsa_pkg::retry_t    t;
		rwsa_pkg::retry_t    m;

		foreach (win_q[i])
			win_q[i] = '0;

		// reset settings 40 / 300 / 6; first record lands 40 in an empty window
		add_item(rwsa_pkg::OP_RECORD, 16'hFFFF, 8'd0,   5);
		add_item(rwsa_pkg::OP_FILL,   16'h0000, 8'hFF,  0);
		add_item(rwsa_pkg::OP_FILL,   16'hFFFF, 8'h00,  65535);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd6,   -1);   // exactly at max_retries
		add_item(rwsa_pkg::OP_FILL,   16'd1000, 8'hAA,  1000); // attempts ignored on fill
		// steepest rising line: saturates high past one retry
		add_cfg(16'h0000, 16'hFFFF, 8'd1);
		add_item(rwsa_pkg::OP_RECORD, 16'h1234, 8'd255, -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd1,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'hFFFF, 8'd0,   -1);
		add_item(rwsa_pkg::OP_FILL,   16'hA5A5, 8'h5A,  16'hA5A5);
		// falling slope at full scale, down to zero at max_retries
		add_cfg(16'hFFFF, 16'h0000, 8'd255);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd0,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd255, -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd128, -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd200, -1);
		// zero divisor, falling line driven below zero
		add_cfg(16'd100, 16'd50, 8'd0);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd1,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd3,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd2,   -1);
		// gentle rise, extrapolation past max and a write-position wrap
		add_cfg(16'd10, 16'd20, 8'd3);
		add_item(rwsa_pkg::OP_FILL,   16'h5A5A, 8'h00,  16'h5A5A);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd0,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd1,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd2,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd3,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd4,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd7,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd9,   -1);
		add_item(rwsa_pkg::OP_RECORD, 16'h0000, 8'd255, -1);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cfg)
				program_regs(row.base, row.top, row.maxr);
			else
				offer(row.op, row.fill, row.tries, row.want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					b  = rwsa_pkg::BASE_INTERVAL_RST;
					tp = rwsa_pkg::TOP_INTERVAL_RST;
					m  = rwsa_pkg::MAX_RETRIES_RST;
				end
				1: begin
					b = 16'h0000; tp = 16'hFFFF; m = 8'd1;
				end
				2: begin
					b = 16'hFFFF; tp = 16'h0000; m = 8'd255;
				end
				3: begin
					b = 16'($urandom); tp = 16'($urandom); m = 8'd0;
				end
				5: begin   // steep rise, saturates high often
					b  = 16'($urandom_range(0, 1000));
					tp = 16'($urandom_range(60000, 65535));
					m  = 8'($urandom_range(1, 4));
				end
				6: begin   // steep fall, saturates at zero often
					b  = 16'($urandom_range(30000, 65535));
					tp = 16'($urandom_range(0, 100));
					m  = 8'($urandom_range(1, 16));
				end
				default: begin
					b = 16'($urandom); tp = 16'($urandom); m = 8'($urandom_range(1, 12));
				end
			endcase
			program_regs(b, tp, m);
			burst = 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// bursts of back-to-back transactions, sometimes with a gap between
				if (burst == 0) begin
					burst = $urandom_range(1, 24);
					gap   = (ph == 1 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					if (gap > 0) begin
						item_valid <= 1'b0;
						repeat (gap) @(negedge clk);
					end
				end
				burst--;
				o = ($urandom_range(0, 4) == 0) ? rwsa_pkg::OP_FILL : rwsa_pkg::OP_RECORD;
				case ($urandom_range(0, 7))
					0:       f = 16'h0000;
					1:       f = 16'hFFFF;
					default: f = 16'($urandom);
				endcase
				// half near the configured maximum, half over the whole range
				if ($urandom_range(0, 1) == 0)
					t = 8'($urandom_range(0, (m > 8'd253) ? 255 : m + 2));
				else
					t = 8'($urandom);
				offer(o, f, t, -1);
			end
		end

		item_valid <= 1'b0;
		while (pending_sleep.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("run covered %0d fills and %0d records over %0d register settings",
			n_fill, n_record, n_cfg);
		$display("%0d results checked, %0d mismatches, long receiver hold-off %s",
			n_checked, errors, held ? "done" : "not reached");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
hdl/rwsa_pkg.sv
hdl/retry_weighted_sleep_averager.sv
tb/tb.sv
